@@ rtl/core/integer_batch_sorter_macros.svh @@
// Assertion macros used by the sorter checker.
`ifndef INTEGER_BATCH_SORTER_MACROS_SVH
`define INTEGER_BATCH_SORTER_MACROS_SVH

// Same-cycle implication.
`define IBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ibs_pkg.sv @@
// Shared types and defaults for the integer batch sorter.
package ibs_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IO_WIDTH       = 32;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

@@ rtl/core/ibs_cell.sv @@
// One cell of the insertion sort chain: holds one element and its valid bit.
module ibs_cell #(
  parameter int DATA_WIDTH = ibs_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ibs_pkg::cell_ctrl_t    ctrl,
  input  logic [DATA_WIDTH-1:0]  din,
  input  logic                   prev_take,
  input  logic [DATA_WIDTH-1:0]  prev_val,
  input  logic                   prev_valid,
  input  logic [DATA_WIDTH-1:0]  next_val,
  input  logic                   next_valid,
  output logic                   take,
  output logic [DATA_WIDTH-1:0]  val_r,
  output logic                   valid_r
);
  import ibs_pkg::*;

  // empty cells act as +inf
  assign take = !valid_r || ($signed(din) < $signed(val_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_INSERT: begin
          if (take) begin
            if (prev_take) begin
              val_r   <= prev_val;
              valid_r <= prev_valid;
            end else begin
              val_r   <= din;
              valid_r <= 1'b1;
            end
          end
        end
        OP_SHIFT: begin
          val_r   <= next_val;
          valid_r <= next_valid;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/integer_batch_sorter.sv @@
// Loading ends with the last input beat; the first result is presented the cycle after it.
// Throughput: one input beat per cycle, then one result beat per cycle while out_ready is set.
// Insertion runs in a chain of DEPTH cells, each comparing the new element against its own.
// Input is not taken while the sorted batch drains from the head cell.
// Reset clears the cell valid bits, element count, overflow flag and drain state.
module integer_batch_sorter #(
  parameter int DEPTH      = ibs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ibs_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ibs_pkg::IO_WIDTH-1:0] in_value_in,
  input  logic                                in_last_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ibs_pkg::IO_WIDTH-1:0] out_value_out,
  output logic                                out_last_out,
  output logic                                out_dropped_any
);
  import ibs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic            ovf_r;
  logic            full;
  logic            in_beat;
  cell_ctrl_t      ctrl;
  logic [DATA_WIDTH-1:0] din;

  logic [DATA_WIDTH-1:0] cell_val   [DEPTH];
  logic                  cell_valid [DEPTH];
  logic                  cell_take  [DEPTH];

  generate
    if (DATA_WIDTH <= IO_WIDTH) begin : g_in_narrow
      assign din = in_value_in[DATA_WIDTH-1:0];
    end else begin : g_in_wide
      assign din = {{(DATA_WIDTH - IO_WIDTH){in_value_in[IO_WIDTH-1]}}, in_value_in};
    end
    if (DATA_WIDTH >= IO_WIDTH) begin : g_out_wide
      assign out_value_out = cell_val[0][IO_WIDTH-1:0];
    end else begin : g_out_narrow
      assign out_value_out = {{(IO_WIDTH - DATA_WIDTH){1'b0}}, cell_val[0]};
    end
  endgenerate

  assign in_ready        = (state_r == ST_LOAD);
  assign out_valid       = (state_r == ST_DRAIN);
  assign out_last_out    = (count_r == CW'(1));
  assign out_dropped_any = ovf_r;
  assign full            = (count_r == CW'(DEPTH));
  assign in_beat         = in_valid && in_ready;

  always_comb begin
    ctrl.op = OP_HOLD;
    if (in_beat && !full) begin
      ctrl.op = OP_INSERT;
    end else if (out_valid && out_ready) begin
      ctrl.op = OP_SHIFT;
    end
  end

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  p_take;
      logic [DATA_WIDTH-1:0] p_val;
      logic                  p_valid;
      logic [DATA_WIDTH-1:0] n_val;
      logic                  n_valid;
      if (i == 0) begin : g_first
        assign p_take  = 1'b0;
        assign p_val   = din;
        assign p_valid = 1'b0;
      end else begin : g_mid
        assign p_take  = cell_take[i-1];
        assign p_val   = cell_val[i-1];
        assign p_valid = cell_valid[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign n_val   = cell_val[i];
        assign n_valid = 1'b0;
      end else begin : g_inner
        assign n_val   = cell_val[i+1];
        assign n_valid = cell_valid[i+1];
      end
      ibs_cell #(
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .din       (din),
        .prev_take (p_take),
        .prev_val  (p_val),
        .prev_valid(p_valid),
        .next_val  (n_val),
        .next_valid(n_valid),
        .take      (cell_take[i]),
        .val_r     (cell_val[i]),
        .valid_r   (cell_valid[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_beat) begin
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= count_r + CW'(1);
            end
            if (in_last_in) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_ready) begin
            count_r <= count_r - CW'(1);
            if (out_last_out) begin
              state_r <= ST_LOAD;
              ovf_r   <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/ibs_checker.sv @@
// Port-level checker for the integer batch sorter, bound to the top level.
`include "integer_batch_sorter_macros.svh"

module ibs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [ibs_pkg::IO_WIDTH-1:0] in_value_in,
  input logic                                in_last_in,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ibs_pkg::IO_WIDTH-1:0] out_value_out,
  input logic                                out_last_out,
  input logic                                out_dropped_any
);

  `IBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value_out) && $stable(out_last_out) && $stable(out_dropped_any), "result beat changed while stalled")
  `IBS_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken while draining")
  `IBS_ASSERT_NEXT(a_close_drains, clk, rst_n, in_valid && in_ready && in_last_in, out_valid, "batch close did not start results")
  `IBS_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_ready && out_last_out, !out_valid && in_ready, "results continued after final beat")
  `IBS_ASSERT_NEXT(a_run_flag, clk, rst_n, out_valid && out_ready && !out_last_out, out_valid && (out_dropped_any == $past(out_dropped_any)), "run ended early or dropped flag changed")

endmodule

bind integer_batch_sorter ibs_checker u_ibs_checker (.*);
